// ----- design/tunnel_slot_table_unit_assert.svh -----
// Assertion macros for the tunnel slot table unit.
`ifndef TUNNEL_SLOT_TABLE_UNIT_ASSERT_SVH
`define TUNNEL_SLOT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tst_pkg.sv -----
// Shared types and codes of the tunnel slot table unit.
package tst_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned NodeW   = 4;
  localparam int unsigned SlotW   = 10;
  localparam int unsigned StatusW = 2;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL      = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic start;
    logic step;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic done;
    logic out_free;
  } stat_t;

endpackage

// ----- design/tst_ctrl.sv -----
// Controller state machine of the tunnel slot table unit.
module tst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tst_pkg::stat_t stat_i,
  output tst_pkg::ctrl_t ctrl_o
);

  tst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tst_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    ctrl_o     = '0;
    case (state_q)
      tst_pkg::ST_CLEAR: begin
        ctrl_o.clr_en = 1'b1;
        if (stat_i.clr_last) begin
          state_d = tst_pkg::ST_IDLE;
        end
      end
      tst_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.start = 1'b1;
          state_d      = tst_pkg::ST_SCAN;
        end
      end
      tst_pkg::ST_SCAN: begin
        ctrl_o.step = stat_i.out_free;
        if (stat_i.out_free && stat_i.done) begin
          state_d = tst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tst_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- design/tst_datapath.sv -----
// Slot memory, scan counter, key compare and result register.
module tst_datapath #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned NODE_BITS   = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tst_pkg::ctrl_t                    ctrl_i,
  output tst_pkg::stat_t                    stat_o,
  input  logic                              command_i,
  input  logic [tst_pkg::KeyW-1:0]          in_tunnel_id_i,
  input  logic [tst_pkg::KeyW-1:0]          out_tunnel_id_i,
  input  logic [tst_pkg::NodeW-1:0]         serving_node_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tst_pkg::StatusW-1:0]       status_o,
  output logic [tst_pkg::NodeW-1:0]         found_node_o,
  output logic [tst_pkg::SlotW-1:0]         slot_index_o
);

  localparam int unsigned AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned EntryW  = 1 + 2 * tst_pkg::KeyW + NODE_BITS;
  localparam int unsigned OutLo   = NODE_BITS;
  localparam int unsigned InLo    = NODE_BITS + tst_pkg::KeyW;
  localparam int unsigned ValidB  = EntryW - 1;
  localparam logic [AW-1:0] LastAddr = AW'(TABLE_DEPTH - 1);

  logic [EntryW-1:0] mem_q [TABLE_DEPTH];

  logic [AW-1:0]                 addr_q, chk_addr_q;
  logic                          issue_done_q, pend_q;
  logic [EntryW-1:0]             rd_q;
  logic                          cmd_q;
  logic [tst_pkg::KeyW-1:0]      key_in_q, key_out_q;
  logic [NODE_BITS-1:0]          node_q;
  logic                          out_valid_q;
  logic [tst_pkg::StatusW-1:0]   status_q;
  logic [tst_pkg::NodeW-1:0]     found_node_q;
  logic [tst_pkg::SlotW-1:0]     slot_index_q;

  logic                          rd_en, match, hit, miss_last, load, we;
  logic [AW-1:0]                 waddr;
  logic [EntryW-1:0]             wdata;
  logic [NODE_BITS+tst_pkg::NodeW-1:0] node_in_ext, node_out_ext;
  logic [tst_pkg::SlotW+AW-1:0]  slot_ext;

  assign node_in_ext  = {{NODE_BITS{1'b0}}, serving_node_i};
  assign node_out_ext = {{tst_pkg::NodeW{1'b0}}, rd_q[NODE_BITS-1:0]};
  assign slot_ext     = {{tst_pkg::SlotW{1'b0}}, chk_addr_q};

  assign rd_en = ctrl_i.step && !issue_done_q;

  always_comb begin
    if (cmd_q == tst_pkg::CMD_DELETE) begin
      match = rd_q[ValidB] && (rd_q[InLo +: tst_pkg::KeyW] == key_in_q) &&
              (rd_q[OutLo +: tst_pkg::KeyW] == key_out_q);
    end else begin
      match = !rd_q[ValidB];
    end
  end

  assign hit       = pend_q && match;
  assign miss_last = pend_q && !match && (chk_addr_q == LastAddr);
  assign load      = ctrl_i.step && (hit || miss_last);

  assign stat_o.clr_last = (addr_q == LastAddr);
  assign stat_o.done     = hit || miss_last;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign we    = ctrl_i.clr_en || (load && hit);
  assign waddr = ctrl_i.clr_en ? addr_q : chk_addr_q;

  always_comb begin
    wdata = rd_q;
    if (ctrl_i.clr_en) begin
      wdata[ValidB] = 1'b0;
    end else if (cmd_q == tst_pkg::CMD_DELETE) begin
      wdata[ValidB] = 1'b0;
    end else begin
      wdata = {1'b1, key_in_q, key_out_q, node_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q       <= mem_q[addr_q];
      chk_addr_q <= addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      pend_q       <= 1'b0;
    end else if (ctrl_i.start) begin
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      pend_q       <= 1'b0;
    end else if (ctrl_i.clr_en) begin
      addr_q <= addr_q + AW'(1);
    end else if (ctrl_i.step) begin
      pend_q <= rd_en;
      if (rd_en) begin
        addr_q <= addr_q + AW'(1);
        if (addr_q == LastAddr) begin
          issue_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      cmd_q     <= command_i;
      key_in_q  <= in_tunnel_id_i;
      key_out_q <= out_tunnel_id_i;
      node_q    <= node_in_ext[NODE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (hit) begin
        status_q     <= tst_pkg::STATUS_OK;
        slot_index_q <= slot_ext[tst_pkg::SlotW-1:0];
        found_node_q <= (cmd_q == tst_pkg::CMD_DELETE) ?
                        node_out_ext[tst_pkg::NodeW-1:0] : '0;
      end else begin
        status_q     <= (cmd_q == tst_pkg::CMD_DELETE) ?
                        tst_pkg::STATUS_NOT_FOUND : tst_pkg::STATUS_FULL;
        slot_index_q <= '0;
        found_node_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign found_node_o = found_node_q;
  assign slot_index_o = slot_index_q;

endmodule

// ----- design/tunnel_slot_table_unit.sv -----
// Top level of the tunnel slot table unit.
// After reset a clearing pass marks every slot free, one slot a cycle; during the pass
// in_stall_o stays high.
// One item at a time; the scan reads one slot a cycle from the slot memory while
// the output is free. Each read is registered, then compared; the result loads on
// the first match or after the last slot; the next item is taken the cycle after.
module tunnel_slot_table_unit #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned NODE_BITS   = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [tst_pkg::KeyW-1:0]    in_tunnel_id_i,
  input  logic [tst_pkg::KeyW-1:0]    out_tunnel_id_i,
  input  logic [tst_pkg::NodeW-1:0]   serving_node_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tst_pkg::StatusW-1:0] status_o,
  output logic [tst_pkg::NodeW-1:0]   found_node_o,
  output logic [tst_pkg::SlotW-1:0]   slot_index_o
);

  tst_pkg::ctrl_t ctrl;
  tst_pkg::stat_t stat;

  tst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  tst_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NODE_BITS   (NODE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .command_i       (command_i),
    .in_tunnel_id_i  (in_tunnel_id_i),
    .out_tunnel_id_i (out_tunnel_id_i),
    .serving_node_i  (serving_node_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_node_o    (found_node_o),
    .slot_index_o    (slot_index_o)
  );

`include "tunnel_slot_table_unit_assert.svh"

  `TST_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted beat did not make the unit busy")
  `TST_ASSERT_NOW(a_status_code, out_valid_o, status_o <= tst_pkg::STATUS_NOT_FOUND, "undefined status code on result")
  `TST_ASSERT_NOW(a_fail_zero, out_valid_o && status_o != tst_pkg::STATUS_OK, slot_index_o == '0 && found_node_o == '0, "failed result carries nonzero slot or node")

endmodule

// ----- tb/sv/tunnel_slot_table_checker.sv -----
// Checker that predicts and compares every result of the tunnel slot table unit.
module tunnel_slot_table_checker
  import tst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               command_i,
  input  logic [KeyW-1:0]    in_tunnel_id_i,
  input  logic [KeyW-1:0]    out_tunnel_id_i,
  input  logic [NodeW-1:0]   serving_node_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [NodeW-1:0]   found_node_i,
  input  logic [SlotW-1:0]   slot_index_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [NodeW-1:0]   node;
    logic [SlotW-1:0]   slot;
  } tunnel_result_t;

  logic               entry_live   [TABLE_DEPTH];
  logic [KeyW-1:0]    entry_in_id  [TABLE_DEPTH];
  logic [KeyW-1:0]    entry_out_id [TABLE_DEPTH];
  logic [NodeW-1:0]   entry_node   [TABLE_DEPTH];
  tunnel_result_t     tunnel_result_q [$];

  function automatic tunnel_result_t apply_tunnel_op(logic cmd, logic [KeyW-1:0] in_id,
                                                     logic [KeyW-1:0] out_id,
                                                     logic [NodeW-1:0] node);
    tunnel_result_t r;
    r.status = (cmd == CMD_ADD) ? STATUS_FULL : STATUS_NOT_FOUND;
    r.node   = '0;
    r.slot   = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cmd == CMD_ADD && !entry_live[i]) begin
        entry_live[i]   = 1'b1;
        entry_in_id[i]  = in_id;
        entry_out_id[i] = out_id;
        entry_node[i]   = node;
        r.status = STATUS_OK;
        r.slot   = SlotW'(i);
        return r;
      end
      if (cmd == CMD_DELETE && entry_live[i] && entry_in_id[i] == in_id &&
          entry_out_id[i] == out_id) begin
        entry_live[i] = 1'b0;
        r.status = STATUS_OK;
        r.node   = entry_node[i];
        r.slot   = SlotW'(i);
        return r;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  initial begin
    errors_o  = 0;
    pending_o = 0;
    results_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    tunnel_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        entry_live[i] = 1'b0;
      end
      tunnel_result_q.delete();
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        tunnel_result_q.push_back(apply_tunnel_op(command_i, in_tunnel_id_i,
                                                  out_tunnel_id_i, serving_node_i));
      end
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (tunnel_result_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected beat, expected none actual status %0d node %0d slot %0d",
                   $time, status_i, found_node_i, slot_index_i);
        end else begin
          want = tunnel_result_q.pop_front();
          check_field("status", 16'(want.status), 16'(status_i));
          check_field("found_node", 16'(want.node), 16'(found_node_i));
          check_field("slot_index", 16'(want.slot), 16'(slot_index_i));
        end
      end
      pending_o = tunnel_result_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_tunnel_slot_table_unit.sv -----
// Stimulus and verdict for the tunnel slot table unit, with its checker beside it.
module tb_tunnel_slot_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tst_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  localparam int          FILL_ITEMS  = 15;
  localparam int          RUN_ITEMS   = 580;
  localparam int          WATCHDOG_NS = 50_000_000;

  typedef struct packed {
    logic [KeyW-1:0] in_id;
    logic [KeyW-1:0] out_id;
  } tunnel_key_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               command_i;
  logic [KeyW-1:0]    in_tunnel_id_i;
  logic [KeyW-1:0]    out_tunnel_id_i;
  logic [NodeW-1:0]   serving_node_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [StatusW-1:0] status_o;
  logic [NodeW-1:0]   found_node_o;
  logic [SlotW-1:0]   slot_index_o;

  int errors;
  int pending;
  int results;
  int ops_sent;
  int tx_idle_pct;
  int rx_idle_pct;

  tunnel_key_t live_keys [$];

  tunnel_slot_table_unit #(
    .TABLE_DEPTH(DEPTH),
    .NODE_BITS  (NodeW)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .in_tunnel_id_i (in_tunnel_id_i),
    .out_tunnel_id_i(out_tunnel_id_i),
    .serving_node_i (serving_node_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_node_o   (found_node_o),
    .slot_index_o   (slot_index_o)
  );

  tunnel_slot_table_checker #(
    .TABLE_DEPTH(DEPTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .command_i      (command_i),
    .in_tunnel_id_i (in_tunnel_id_i),
    .out_tunnel_id_i(out_tunnel_id_i),
    .serving_node_i (serving_node_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .found_node_i   (found_node_o),
    .slot_index_i   (slot_index_o),
    .errors_o       (errors),
    .pending_o      (pending),
    .results_o      (results)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  task automatic send_op(logic cmd, logic [KeyW-1:0] in_id, logic [KeyW-1:0] out_id,
                         logic [NodeW-1:0] node);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    in_tunnel_id_i  <= in_id;
    out_tunnel_id_i <= out_id;
    serving_node_i  <= node;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ops_sent++;
  endtask

  function automatic logic [KeyW-1:0] pick_key_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return KeyW'(1) << $urandom_range(0, KeyW - 1);
      default: return KeyW'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    tunnel_key_t k;
    int          idx;
    int          sel;
    int          add_pct;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    command_i       <= CMD_ADD;
    in_tunnel_id_i  <= '0;
    out_tunnel_id_i <= '0;
    serving_node_i  <= '0;
    out_stall_i     <= 1'b0;
    ops_sent    = 0;
    tx_idle_pct = 37;
    rx_idle_pct = 65;
    add_pct     = 50;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(CMD_DELETE, '0, '0, '1);
    send_op(CMD_ADD, '0, '0, '0);
    send_op(CMD_ADD, '1, '1, '1);
    send_op(CMD_ADD, '0, '0, NodeW'(5));
    send_op(CMD_DELETE, '0, '0, NodeW'(10));
    send_op(CMD_DELETE, '0, '0, '0);
    send_op(CMD_DELETE, '0, '0, '0);
    send_op(CMD_DELETE, '1, '0, '0);
    for (int s = 0; s < FILL_ITEMS; s++) begin
      k.in_id  = 32'hA500_0000 | KeyW'(s);
      k.out_id = ~k.in_id;
      live_keys.push_back(k);
      send_op(CMD_ADD, k.in_id, k.out_id, NodeW'(s));
    end
    send_op(CMD_ADD, 32'h1234_5678, 32'h8765_4321, NodeW'(9));
    send_op(CMD_DELETE, '1, '1, '0);

    for (int n = 0; n < RUN_ITEMS; n++) begin
      if (n == RUN_ITEMS / 3) begin
        tx_idle_pct = 65;
        rx_idle_pct = 37;
      end
      if (n == 2 * RUN_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (n % 50 == 0) begin
        add_pct = $urandom_range(20, 80);
      end
      if ($urandom_range(0, 99) < add_pct) begin
        if (live_keys.size() != 0 && $urandom_range(0, 9) == 0) begin
          k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        end else begin
          k.in_id  = pick_key_word();
          k.out_id = pick_key_word();
        end
        live_keys.push_back(k);
        if (live_keys.size() > 4 * DEPTH) begin
          live_keys.delete(0);
        end
        send_op(CMD_ADD, k.in_id, k.out_id, NodeW'($urandom));
      end else begin
        sel = $urandom_range(0, 99);
        if (live_keys.size() != 0 && sel < 65) begin
          idx = $urandom_range(0, live_keys.size() - 1);
          k   = live_keys[idx];
          live_keys.delete(idx);
        end else if (live_keys.size() != 0 && sel < 80) begin
          k = live_keys[$urandom_range(0, live_keys.size() - 1)];
          if ($urandom_range(0, 1)) begin
            k.in_id[$urandom_range(0, KeyW - 1)] ^= 1'b1;
          end else begin
            k.out_id[$urandom_range(0, KeyW - 1)] ^= 1'b1;
          end
        end else begin
          k.in_id  = pick_key_word();
          k.out_id = pick_key_word();
        end
        send_op(CMD_DELETE, k.in_id, k.out_id, NodeW'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    wait (results >= ops_sent);
    repeat (DEPTH + 8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
